// ===== sv/tjdq_pkg.sv =====
// Shared types and constants of the timed job dispatch queue.
// Field widths, request, status and operation codes, and the controller/datapath links.
// No dependencies.
package tjdq_pkg;

   localparam int TAG_W    = 8;
   localparam int DELAY_W  = 24;
   localparam int TIME_W   = 32;
   localparam int DUE_W    = 33;
   localparam int REQ_W    = 2;
   localparam int STATUS_W = 3;

   typedef enum logic [REQ_W-1:0] {
      REQ_SUBMIT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_TICK   = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED     = 3'd0,
      ST_FULL       = 3'd1,
      ST_DELETED    = 3'd2,
      ST_EMPTY      = 3'd3,
      ST_DISPATCHED = 3'd4,
      ST_NOTHING    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_POP    = 2'd2
   } op_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;    // capture the request transaction
      logic       update;  // apply op and load the response register
      op_type     op;
      status_type status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic             full;
      logic             empty;
      logic             head_due;
   } stat_type;

endpackage

// ===== sv/tjdq_if.sv =====
// Handshake channels of the timed job dispatch queue: request and response.
// Depends on tjdq_pkg for field widths.
interface tjdq_req_if;
   logic                         valid;
   logic                         ready;
   logic [tjdq_pkg::REQ_W-1:0]   req_type;
   logic [tjdq_pkg::TAG_W-1:0]   job_tag;
   logic [tjdq_pkg::DELAY_W-1:0] delay;
   logic [tjdq_pkg::TIME_W-1:0]  now;

   modport source (output valid, output req_type, output job_tag, output delay,
                   output now, input ready);
   modport sink   (input valid, input req_type, input job_tag, input delay,
                   input now, output ready);
endinterface

interface tjdq_rsp_if #(parameter int QW = 5);
   logic                          valid;
   logic                          ready;
   logic [tjdq_pkg::STATUS_W-1:0] status;
   logic [tjdq_pkg::TAG_W-1:0]    out_tag;
   logic [tjdq_pkg::DUE_W-1:0]    out_due;
   logic [tjdq_pkg::TIME_W-1:0]   out_submit;
   logic [QW-1:0]                 queued;

   modport source (output valid, output status, output out_tag, output out_due,
                   output out_submit, output queued, input ready);
   modport sink   (input valid, input status, input out_tag, input out_due,
                   input out_submit, input queued, output ready);
endinterface

// ===== sv/tjdq_ctrl.sv =====
// Controller of the timed job dispatch queue: sequences capture, compare and update.
// Depends on tjdq_pkg.
module tjdq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  tjdq_pkg::stat_type stat,
   output tjdq_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE
   } state_type;

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   tjdq_pkg::op_type       op_ff, op_in;
   tjdq_pkg::status_type   status_ff, status_in;
   logic                   accept;
   logic                   do_update;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   // Hold the update while an earlier response is still unclaimed
   assign do_update = (state_ff == S_UPDATE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   assign cmd.load   = accept;
   assign cmd.update = do_update;
   assign cmd.op     = op_ff;
   assign cmd.status = status_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            state_in = S_UPDATE;
            case (stat.req_type)
               tjdq_pkg::REQ_SUBMIT: begin
                  op_in     = stat.full ? tjdq_pkg::OP_NONE : tjdq_pkg::OP_INSERT;
                  status_in = stat.full ? tjdq_pkg::ST_FULL : tjdq_pkg::ST_QUEUED;
               end
               tjdq_pkg::REQ_DELETE: begin
                  op_in     = stat.empty ? tjdq_pkg::OP_NONE : tjdq_pkg::OP_POP;
                  status_in = stat.empty ? tjdq_pkg::ST_EMPTY : tjdq_pkg::ST_DELETED;
               end
               tjdq_pkg::REQ_TICK: begin
                  if (!stat.empty && stat.head_due) begin
                     op_in     = tjdq_pkg::OP_POP;
                     status_in = tjdq_pkg::ST_DISPATCHED;
                  end else begin
                     op_in     = tjdq_pkg::OP_NONE;
                     status_in = tjdq_pkg::ST_NOTHING;
                  end
               end
               default: begin
                  op_in     = tjdq_pkg::OP_NONE;
                  status_in = tjdq_pkg::ST_NOTHING;
               end
            endcase
         end
         S_UPDATE: begin
            if (do_update) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         op_ff        <= tjdq_pkg::OP_NONE;
         status_ff    <= tjdq_pkg::ST_NOTHING;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
         status_ff    <= status_in;
      end
   end

endmodule

// ===== sv/tjdq_dpath.sv =====
// Datapath of the timed job dispatch queue: sorted slot row, request and response registers.
// Depends on tjdq_pkg.
module tjdq_dpath #(
   parameter int DEPTH = 16,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tjdq_pkg::cmd_type             cmd,
   output tjdq_pkg::stat_type            stat,
   input  logic [tjdq_pkg::REQ_W-1:0]    req_type,
   input  logic [tjdq_pkg::TAG_W-1:0]    job_tag,
   input  logic [tjdq_pkg::DELAY_W-1:0]  delay,
   input  logic [tjdq_pkg::TIME_W-1:0]   now,
   output logic [tjdq_pkg::STATUS_W-1:0] status,
   output logic [tjdq_pkg::TAG_W-1:0]    out_tag,
   output logic [tjdq_pkg::DUE_W-1:0]    out_due,
   output logic [tjdq_pkg::TIME_W-1:0]   out_submit,
   output logic [CW-1:0]                 queued
);

   // Slot row, slot 0 is the head
   logic [tjdq_pkg::TAG_W-1:0]  tag_ff [DEPTH];
   logic [tjdq_pkg::DUE_W-1:0]  due_ff [DEPTH];
   logic [tjdq_pkg::TIME_W-1:0] sub_ff [DEPTH];
   logic [CW-1:0]               count_ff, count_in;

   logic [tjdq_pkg::REQ_W-1:0]  req_ff;
   logic [tjdq_pkg::TAG_W-1:0]  new_tag_ff;
   logic [tjdq_pkg::DUE_W-1:0]  new_due_ff;
   logic [tjdq_pkg::TIME_W-1:0] now_ff;
   logic [DEPTH-1:0]            keep_ff, keep_in;

   logic [tjdq_pkg::STATUS_W-1:0] status_ff;
   logic [tjdq_pkg::TAG_W-1:0]    out_tag_ff;
   logic [tjdq_pkg::DUE_W-1:0]    out_due_ff;
   logic [tjdq_pkg::TIME_W-1:0]   out_sub_ff;
   logic [CW-1:0]                 queued_ff;

   assign stat.req_type = req_ff;
   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.head_due = ({1'b0, now_ff} >= due_ff[0]);

   // A slot stays put when it is occupied and not later than the new job
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keep_in[i] = (CW'(i) < count_ff) && (due_ff[i] <= new_due_ff);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.update) begin
         case (cmd.op)
            tjdq_pkg::OP_INSERT: count_in = count_ff + CW'(1);
            tjdq_pkg::OP_POP:    count_in = count_ff - CW'(1);
            default:             count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      keep_ff <= keep_in;
      if (cmd.load) begin
         req_ff     <= req_type;
         new_tag_ff <= job_tag;
         new_due_ff <= {1'b0, now} + {{(tjdq_pkg::DUE_W - tjdq_pkg::DELAY_W){1'b0}}, delay};
         now_ff     <= now;
      end
   end

   // Shift the row right past the insert point, or left on a pop
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int i = 0; i < DEPTH; i++) begin
            case (cmd.op)
               tjdq_pkg::OP_INSERT: begin
                  if (!keep_ff[i]) begin
                     if (i == 0 || keep_ff[(i == 0) ? 0 : i - 1]) begin
                        tag_ff[i] <= new_tag_ff;
                        due_ff[i] <= new_due_ff;
                        sub_ff[i] <= now_ff;
                     end else begin
                        tag_ff[i] <= tag_ff[(i == 0) ? 0 : i - 1];
                        due_ff[i] <= due_ff[(i == 0) ? 0 : i - 1];
                        sub_ff[i] <= sub_ff[(i == 0) ? 0 : i - 1];
                     end
                  end
               end
               tjdq_pkg::OP_POP: begin
                  if (i < DEPTH - 1) begin
                     tag_ff[i] <= tag_ff[(i < DEPTH - 1) ? i + 1 : i];
                     due_ff[i] <= due_ff[(i < DEPTH - 1) ? i + 1 : i];
                     sub_ff[i] <= sub_ff[(i < DEPTH - 1) ? i + 1 : i];
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         status_ff <= cmd.status;
         queued_ff <= count_in;
         if (cmd.op == tjdq_pkg::OP_POP) begin
            out_tag_ff <= tag_ff[0];
            out_due_ff <= due_ff[0];
            out_sub_ff <= sub_ff[0];
         end else begin
            out_tag_ff <= '0;
            out_due_ff <= '0;
            out_sub_ff <= '0;
         end
      end
   end

   assign status     = status_ff;
   assign out_tag    = out_tag_ff;
   assign out_due    = out_due_ff;
   assign out_submit = out_sub_ff;
   assign queued     = queued_ff;

endmodule

// ===== sv/timed_job_dispatch_queue_core.sv =====
// Top level of the timed job dispatch queue.
// Depends on tjdq_pkg, tjdq_req_if, tjdq_rsp_if, tjdq_ctrl and tjdq_dpath.
//
// Usage:
//   req_ch carries one transaction per command: submit (tag, delay, now),
//   delete head, or tick (now). rsp_ch returns exactly one transaction per
//   request with status, the removed job's tag, due and submit times (zero
//   when no job leaves), and the job count after the command.
//   Jobs sit in a row of DEPTH slots sorted by due time = now + delay
//   (33 bits, no wrap); equal due times keep arrival order.
// Timing:
//   A request is taken only while the controller is idle, so a new request
//   waits until the last one has finished its update step. The accepting edge
//   latches the request and forms the due time, a compare step checks it against
//   every slot in parallel and picks the operation, and an update step shifts the
//   slot row, loads the response register and raises the response valid.
// Reset:
//   reset (synchronous, active high) empties the queue and drops any pending
//   response. Slot contents are not cleared; only occupied slots are read.
// Stall:
//   While a response is valid and rsp_ch.ready is low the response register
//   holds. One further request is accepted and processed up to the update step,
//   which waits until the held response is taken.
module timed_job_dispatch_queue_core #(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   tjdq_req_if.sink        req_ch,
   tjdq_rsp_if.source      rsp_ch
);

   localparam int CW = $clog2(DEPTH + 1);

   tjdq_pkg::cmd_type  cmd;
   tjdq_pkg::stat_type stat;
   logic [CW-1:0]      queued;

   tjdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tjdq_dpath #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_type   (req_ch.req_type),
      .job_tag    (req_ch.job_tag),
      .delay      (req_ch.delay),
      .now        (req_ch.now),
      .status     (rsp_ch.status),
      .out_tag    (rsp_ch.out_tag),
      .out_due    (rsp_ch.out_due),
      .out_submit (rsp_ch.out_submit),
      .queued     (queued)
   );

   // Count width follows DEPTH; the channel carries it as queued
   assign rsp_ch.queued = queued;

endmodule

// ===== dv/timed_job_dispatch_queue_core_test.sv =====
// Self-checking testbench for timed_job_dispatch_queue_core: directed table, then random
// traffic, each response checked against a typed value or a model of the sorted job queue.
// Depends on tjdq_pkg, tjdq_req_if, tjdq_rsp_if and the queue RTL.
module timed_job_dispatch_queue_core_test;
   import tjdq_pkg::*;

   localparam int DEPTH        = 16;
   localparam int QUEUED_W     = $clog2(DEPTH + 1);
   localparam int RANDOM_ITEMS = 900;
   localparam int PHASE_ITEMS  = 60;
   localparam int HOLD_AFTER   = 400;   // responses seen before the long receiver hold
   localparam int LONG_HOLD    = 300;   // cycles of the long receiver hold
   localparam int TAIL_CYCLES  = 12;    // settle time after the last response
   localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction before giving up
   localparam int REPORT_MAX   = 10;

   // req_type has one unused encoding; the block must ignore it
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [REQ_W-1:0]   kind;
      logic [TAG_W-1:0]   tag;
      logic [DELAY_W-1:0] delay;
      logic [TIME_W-1:0]  now;
   } job_req_t;

   typedef struct packed {
      status_type          status;
      logic [TAG_W-1:0]    tag;
      logic [DUE_W-1:0]    due;
      logic [TIME_W-1:0]   submit;
      logic [QUEUED_W-1:0] queued;
   } job_rsp_t;

   typedef struct packed {
      job_req_t req;
      bit       typed;   // response below is written out by hand
      job_rsp_t rsp;
   } dir_row_t;

   localparam job_rsp_t NO_RSP = '0;

   logic clock;
   logic reset;

   tjdq_req_if                  req_ch ();
   tjdq_rsp_if #(.QW(QUEUED_W)) rsp_ch ();

   timed_job_dispatch_queue_core #(.DEPTH(DEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Directed table. Opening rows probe the empty queue and the field extremes
   // with responses written out; then sixteen submits fill the queue with due-time
   // ties reached from different submit/delay pairs, one more submit must be
   // dropped, and two ticks dispatch, the first from the full queue.
   dir_row_t dir_rows [25] = '{
      // delete and tick on an empty queue, then the unused request code
      '{'{REQ_DELETE, 8'h00, 24'h000000, 32'h0000_0000}, 1'b1,
        '{ST_EMPTY,   8'h00, 33'h0, 32'h0, 5'd0}},
      '{'{REQ_TICK,   8'h00, 24'h000000, 32'hFFFF_FFFF}, 1'b1,
        '{ST_NOTHING, 8'h00, 33'h0, 32'h0, 5'd0}},
      '{'{REQ_UNUSED, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF}, 1'b1,
        '{ST_NOTHING, 8'h00, 33'h0, 32'h0, 5'd0}},
      // largest due time: carries into bit 32, so even the latest tick is early
      '{'{REQ_SUBMIT, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF}, 1'b1,
        '{ST_QUEUED,  8'h00, 33'h0, 32'h0, 5'd1}},
      '{'{REQ_TICK,   8'h00, 24'h000000, 32'hFFFF_FFFF}, 1'b1,
        '{ST_NOTHING, 8'h00, 33'h0, 32'h0, 5'd1}},
      '{'{REQ_DELETE, 8'h00, 24'h000000, 32'h0000_0000}, 1'b1,
        '{ST_DELETED, 8'hFF, 33'h1_00FF_FFFE, 32'hFFFF_FFFF, 5'd0}},
      // fill to DEPTH; due 0 twice and due 1100 five times must stay in arrival order
      '{'{REQ_SUBMIT, 8'h01, 24'h000000, 32'h0000_0000}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h02, 24'h000064, 32'h0000_03E8}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h03, 24'h00044C, 32'h0000_0000}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h04, 24'h000032, 32'h0000_041A}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h05, 24'h00000A, 32'h0000_03E8}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h06, 24'h000000, 32'h0000_044C}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h07, 24'hFFFFFF, 32'hFFFF_FFFF}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h08, 24'h000001, 32'hFFFF_FFFE}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h09, 24'h000000, 32'h0000_0000}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h0A, 24'h000123, 32'h0000_0800}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h0B, 24'h800000, 32'h8000_0000}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h0C, 24'h00ABCD, 32'h0000_0500}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h0D, 24'h000000, 32'h0000_044C}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h0E, 24'h7FFFFF, 32'h7FFF_FFFF}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h0F, 24'h000010, 32'h0000_0010}, 1'b0, NO_RSP},
      '{'{REQ_SUBMIT, 8'h10, 24'h555555, 32'hAAAA_AAAA}, 1'b0, NO_RSP},
      // full queue drops the job and reports the unchanged count
      '{'{REQ_SUBMIT, 8'h11, 24'h000005, 32'h0000_0005}, 1'b1,
        '{ST_FULL,    8'h00, 33'h0, 32'h0, 5'd16}},
      '{'{REQ_TICK,   8'h00, 24'h000000, 32'h0000_0000}, 1'b0, NO_RSP},
      '{'{REQ_TICK,   8'h00, 24'h000000, 32'hFFFF_FFFF}, 1'b0, NO_RSP}
   };

   // ------------------------------------------------------------------
   // Queue model: slot 0 is the head, slots below job_total are valid
   // ------------------------------------------------------------------
   logic [TAG_W-1:0]  model_tag    [DEPTH];
   logic [DUE_W-1:0]  model_due    [DEPTH];
   logic [TIME_W-1:0] model_submit [DEPTH];
   int unsigned       job_total;

   job_rsp_t expected_rsp_q [$];

   int  mismatches;
   int  results_seen;
   int  idle_cycles;
   bit  long_hold_done;
   int  req_tally [4];
   int  status_tally [8];

   // state of the random stream
   logic [TIME_W-1:0] wall_clock;
   bit                fill_phase;
   bit                sender_steady;

   // Remove the head job into the response and close the gap behind it.
   function automatic void take_head(inout job_rsp_t rsp);
      rsp.tag    = model_tag[0];
      rsp.due    = model_due[0];
      rsp.submit = model_submit[0];
      for (int i = 1; i < job_total; i++) begin
         model_tag[i-1]    = model_tag[i];
         model_due[i-1]    = model_due[i];
         model_submit[i-1] = model_submit[i];
      end
      job_total--;
   endfunction

   // Apply one request to the model and return the response it must produce.
   function automatic job_rsp_t predict_queue_step(job_req_t req);
      job_rsp_t         rsp;
      logic [DUE_W-1:0] due;
      int unsigned      pos;
      rsp        = '0;
      rsp.status = ST_NOTHING;
      case (req.kind)
         REQ_SUBMIT: begin
            if (job_total >= DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               due = {1'b0, req.now} + DUE_W'(req.delay);
               // place behind every job due at the same time or earlier
               pos = 0;
               while (pos < job_total && model_due[pos] <= due) pos++;
               for (int i = job_total; i > pos; i--) begin
                  model_tag[i]    = model_tag[i-1];
                  model_due[i]    = model_due[i-1];
                  model_submit[i] = model_submit[i-1];
               end
               model_tag[pos]    = req.tag;
               model_due[pos]    = due;
               model_submit[pos] = req.now;
               job_total++;
               rsp.status = ST_QUEUED;
            end
         end
         REQ_DELETE: begin
            if (job_total == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               take_head(rsp);
               rsp.status = ST_DELETED;
            end
         end
         REQ_TICK: begin
            if (job_total != 0 && {1'b0, req.now} >= model_due[0]) begin
               take_head(rsp);
               rsp.status = ST_DISPATCHED;
            end
         end
         default: ;
      endcase
      rsp.queued = QUEUED_W'(job_total);
      return rsp;
   endfunction

   // Idle length: mostly a few cycles, now and then a long one.
   function automatic int stall_len();
      if ($urandom_range(9, 0) != 0) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic int sender_gap();
      if (sender_steady || $urandom_range(99, 0) < 60) return 0;
      return stall_len();
   endfunction

   // Random request. Most traffic is well-formed: submits at the running wall
   // clock with short delays, deletes, and ticks that advance it, so jobs really come due.
   // The rest is noise over the full field ranges and the unused request code.
   function automatic job_req_t make_job_request();
      job_req_t req;
      int       roll;
      req.kind  = REQ_TICK;
      req.tag   = TAG_W'($urandom);
      req.delay = DELAY_W'($urandom);
      req.now   = $urandom;
      roll = $urandom_range(99, 0);
      if (roll < 3) begin
         req.kind = REQ_UNUSED;
         return req;
      end
      if (roll < 10) begin
         req.kind = REQ_W'($urandom_range(2, 0));
         return req;
      end
      roll = $urandom_range(99, 0);
      if (roll < (fill_phase ? 65 : 25)) begin
         req.kind = REQ_SUBMIT;
         roll = $urandom_range(99, 0);
         if (roll < 80)      req.delay = DELAY_W'($urandom_range(40, 0));
         else if (roll < 95) req.delay = DELAY_W'($urandom_range(1000, 0));
         req.now = wall_clock;
      end else if (roll < (fill_phase ? 72 : 35)) begin
         req.kind = REQ_DELETE;
      end else begin
         // advance the wall clock, with the occasional jump
         if ($urandom_range(19, 0) == 0) wall_clock += $urandom_range(2000, 0);
         else                            wall_clock += $urandom_range(8, 0);
         req.now = wall_clock;
      end
      return req;
   endfunction

   // Offer one request, hold it until accepted, then queue its expected response.
   task automatic offer_job_request(input job_req_t req, input bit typed,
                                    input job_rsp_t typed_rsp);
      job_rsp_t predicted;
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= req.kind;
      req_ch.job_tag  <= req.tag;
      req_ch.delay    <= req.delay;
      req_ch.now      <= req.now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_queue_step(req);
      expected_rsp_q.push_back(typed ? typed_rsp : predicted);
      req_tally[req.kind]++;
   endtask

   // Drop valid for a gap and, if asked, until every response is back.
   // The queue is never empty right after an acceptance, so a drain always
   // waits on the clock before the next offer raises valid again.
   task automatic idle_sender(input int gap, input bit drain);
      if (gap == 0 && !drain) return;
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clock);
      if (drain) begin
         while (expected_rsp_q.size() != 0) @(posedge clock);
      end
   endtask

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Response side: random back-pressure with one long hold
   // ------------------------------------------------------------------
   initial begin : rsp_pacing
      bit steady;
      rsp_ch.ready <= 1'b0;
      steady = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            // hold off long enough for the block to fill and stall its input
            long_hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if ($urandom_range(9, 0) == 0) steady = !steady;
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge clock);
            if (!steady) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall_len()) @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response checker and activity counter for the watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      job_rsp_t seen;
      job_rsp_t want;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.status = status_type'(rsp_ch.status);
            seen.tag    = rsp_ch.out_tag;
            seen.due    = rsp_ch.out_due;
            seen.submit = rsp_ch.out_submit;
            seen.queued = rsp_ch.queued;
            results_seen++;
            status_tally[seen.status]++;
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"response with nothing pending: status %0d tag %02h",
                            " due %09h submit %08h queued %0d"},
                           seen.status, seen.tag, seen.due, seen.submit, seen.queued);
            end else begin
               want = expected_rsp_q.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("response %0d mismatch", results_seen);
                     $display("   expected status %0d tag %02h due %09h submit %08h queued %0d",
                              want.status, want.tag, want.due, want.submit, want.queued);
                     $display("   actual   status %0d tag %02h due %09h submit %08h queued %0d",
                              seen.status, seen.tag, seen.due, seen.submit, seen.queued);
                  end
               end
            end
         end
      end
   end

   // Give up once nothing has moved on either channel for too long.
   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("timeout: no transaction for %0d cycles, %0d responses pending",
               IDLE_LIMIT, expected_rsp_q.size());
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------
   // Request side: directed table, then random phases
   // ------------------------------------------------------------------
   initial begin : stimulus
      job_req_t req;
      int       counted;
      int       phase_left;
      bit       paused;

      job_total      = 0;
      mismatches     = 0;
      results_seen   = 0;
      idle_cycles    = 0;
      long_hold_done = 1'b0;
      sender_steady  = 1'b0;
      fill_phase     = 1'b1;
      wall_clock     = '0;
      foreach (req_tally[i]) req_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;

      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_SUBMIT;
      req_ch.job_tag  <= '0;
      req_ch.delay    <= '0;
      req_ch.now      <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      foreach (dir_rows[i]) begin
         offer_job_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
         idle_sender(sender_gap(), 1'b0);
      end

      counted    = 0;
      phase_left = 0;
      paused     = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            // alternate filling and draining; sometimes rebase the wall clock,
            // now and then close to the top of the 32-bit range
            phase_left    = PHASE_ITEMS;
            fill_phase    = ($urandom_range(3, 0) == 0) ? fill_phase : !fill_phase;
            sender_steady = ($urandom_range(3, 0) == 0);
            if ($urandom_range(9, 0) < 3) begin
               if ($urandom_range(4, 0) == 0)
                  wall_clock = 32'hFFFF_F000 + $urandom_range(32'hFFF, 0);
               else
                  wall_clock = $urandom;
            end
         end
         req = make_job_request();
         offer_job_request(req, 1'b0, NO_RSP);
         if (req.kind != REQ_UNUSED) begin
            counted++;
            phase_left--;
         end
         if (!paused && counted >= RANDOM_ITEMS / 2) begin
            // pause until the block has answered everything
            paused = 1'b1;
            idle_sender($urandom_range(3, 0), 1'b1);
         end else begin
            idle_sender(sender_gap(), 1'b0);
         end
      end
      req_ch.valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("requests: %0d submit, %0d delete, %0d tick, %0d unused code",
               req_tally[REQ_SUBMIT], req_tally[REQ_DELETE], req_tally[REQ_TICK],
               req_tally[REQ_UNUSED]);
      $display({"responses: %0d queued, %0d dropped full, %0d deleted, %0d empty,",
                " %0d dispatched, %0d not due"},
               status_tally[ST_QUEUED], status_tally[ST_FULL], status_tally[ST_DELETED],
               status_tally[ST_EMPTY], status_tally[ST_DISPATCHED], status_tally[ST_NOTHING]);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d responses failed the check", mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
